### hw/rtl/cbds_pkg.sv
// Package for the CSI baseline deviation scorer.
// Beat types, sequencer states, register codes and arithmetic constants.
// No dependencies.
package cbds_pkg;

	localparam int MAX_SUB_DEF = 128;

	localparam logic [15:0] CAL_TARGET_RST = 16'd3000;
	localparam logic [15:0] STD_FLOOR_RST  = 16'd26;

	localparam logic REG_CAL_TARGET = 1'b0;
	localparam logic REG_STD_FLOOR  = 1'b1;

	localparam logic [18:0] DEV_SAT   = 19'h7FFFF;
	localparam logic [9:0]  PERM_FULL = 10'd1000;

	// restoring divider: dividend and divisor widths, one quotient bit a cycle
	localparam int DV_NW = 48;
	localparam int DV_DW = 16;
	// square root: radicand width and iteration count
	localparam int SQ_W     = 32;
	localparam int SQ_STEPS = 16;
	localparam logic [SQ_W-1:0] SQ_BIT0 = 32'h4000_0000;

	typedef struct packed {
		logic signed [7:0] q_part;
		logic signed [7:0] r_part;
		logic              last_in_frame;
	} sub_beat_t;

	typedef struct packed {
		logic [7:0]  subcarrier_count;
		logic [15:0] mean_amplitude;
		logic [18:0] avg_zscore;
		logic        calibrated;
		logic [15:0] calibration_frames;
		logic [9:0]  calibration_permille;
	} res_beat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PWR,
		ST_AMP,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_FRM,
		ST_FIN_RD,
		ST_FIN_LD,
		ST_FIN_DM,
		ST_FIN_DP,
		ST_FIN_VAR,
		ST_FIN_SQ,
		ST_FIN_WR,
		ST_SC_RD,
		ST_SC_LD,
		ST_SC_DIV,
		ST_MEAN_LD,
		ST_MEAN,
		ST_DEV_LD,
		ST_DEV,
		ST_PERM_LD,
		ST_PERM,
		ST_OUT
	} state_t;

endpackage

### hw/rtl/csi_baseline_deviation_scorer.sv
// CSI baseline deviation scorer, top level.
// Depends on cbds_pkg and cbds_ram.
//
// Usage:
// One subcarrier beat (q_part, r_part, last_in_frame) enters on sub_valid/sub_ready.
// sub_ready is high only while the sequencer is idle. Each beat goes through
// a power product, a 16-step shared square-root iteration for the
// amplitude, then a read-modify-write of the calibration sums.
// A beat flagged last_in_frame produces one result beat on res_valid/res_ready.
// Frame end adds up to three divisions (mean amplitude, average z-score,
// progress), each after a load state, plus one scoring division per
// subcarrier once calibrated.
// The frame that completes calibration also runs the finalize sweep over all
// MAX_SUB entries, each with two divisions and one root.
// All division goes through one restoring divider, one bit a cycle.
// The result sits in an output register; a stalled receiver holds the
// sequencer only when the next result is ready while the last is untaken.
// Reset clears the sums through per-entry valid bits, so no clearing pass is
// needed; configuration comes back to cal_target 3000, std_floor 26.
// Configuration: APB, cal_target at 0x0, std_floor at 0x4, write while idle.
module csi_baseline_deviation_scorer
	import cbds_pkg::*;
#(
	parameter int MAX_SUB = MAX_SUB_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sub_valid,
	output logic        sub_ready,
	input  sub_beat_t   sub_beat,
	output logic        res_valid,
	input  logic        res_ready,
	output res_beat_t   res_beat,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W  = (MAX_SUB > 1) ? $clog2(MAX_SUB) : 1;
	localparam int CNT_W  = $clog2(MAX_SUB + 1);
	localparam int ATOT_W = 16 + CNT_W;
	localparam int DTOT_W = 19 + CNT_W;
	localparam int STEP_W = $clog2(DV_NW);

	state_t state_q, state_d;

	logic [15:0] cal_target_q, std_floor_q;
	logic [STEP_W-1:0] cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  sub_cnt_q;
	logic [15:0]       cal_cnt_q;
	logic              cal_done_q;
	logic [MAX_SUB-1:0] sum_vld_q;
	logic              vld_rd_q;
	logic [ATOT_W-1:0] amp_tot_q;
	logic              res_valid_q;
	res_beat_t         res_q;

	sub_beat_t         beat_q;
	logic [15:0]       p_q;
	logic [SQ_W-1:0]   sq_v_q, sq_res_q, sq_bit_q;
	logic [DV_NW-1:0]  dv_num_q;
	logic [DV_DW-1:0]  dv_den_q, dv_rem_q;
	logic [31:0]       psum_q, pw_q, m2_q;
	logic [15:0]       mean_q, mamp_q;
	logic [DTOT_W-1:0] dev_tot_q;
	logic [18:0]       dev_q;
	logic [9:0]        perm_q;

	// APB
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_STD_FLOOR) ? {16'b0, std_floor_q} : {16'b0, cal_target_q};

	// shared units
	logic signed [15:0] qq, rr;
	logic [15:0]        p_c;
	assign qq  = beat_q.q_part * beat_q.q_part;
	assign rr  = beat_q.r_part * beat_q.r_part;
	assign p_c = $unsigned(qq) + $unsigned(rr);

	logic [DV_DW:0]   rem_sh;
	logic             dv_ge;
	logic [DV_DW-1:0] rem_nx;
	logic [DV_NW-1:0] quot_nx;
	assign rem_sh  = {dv_rem_q, dv_num_q[DV_NW-1]};
	assign dv_ge   = rem_sh >= {1'b0, dv_den_q};
	assign rem_nx  = dv_ge ? DV_DW'(rem_sh - {1'b0, dv_den_q}) : DV_DW'(rem_sh);
	assign quot_nx = {dv_num_q[DV_NW-2:0], dv_ge};

	logic [SQ_W-1:0] sq_t, sq_rnd;
	logic            sq_ge;
	assign sq_t   = sq_res_q + sq_bit_q;
	assign sq_ge  = sq_v_q >= sq_t;
	assign sq_rnd = sq_res_q + {{(SQ_W-1){1'b0}}, sq_v_q > sq_res_q};

	logic div_run, sq_run, step_last;
	always_comb begin
		div_run = 1'b0;
		sq_run  = 1'b0;
		case (state_q)
			ST_FIN_DM, ST_FIN_DP, ST_SC_DIV, ST_MEAN, ST_DEV, ST_PERM: div_run = 1'b1;
			ST_AMP, ST_FIN_SQ: sq_run = 1'b1;
			default: ;
		endcase
	end
	assign step_last = div_run ? (cnt_q == STEP_W'(DV_NW - 1)) : (cnt_q == STEP_W'(SQ_STEPS - 1));

	// status
	logic        sub_full, idx_last, sc_last, fin_go, perm_full, sub_any, take_out;
	logic [15:0] cnt_inc, flo, n16;
	assign sub_full  = sub_cnt_q >= CNT_W'(MAX_SUB);
	assign sub_any   = sub_cnt_q != '0;
	assign idx_last  = idx_q == IDX_W'(MAX_SUB - 1);
	assign sc_last   = (CNT_W'(idx_q) + CNT_W'(1)) >= sub_cnt_q;
	assign cnt_inc   = (cal_cnt_q == 16'hFFFF) ? cal_cnt_q : cal_cnt_q + 16'd1;
	assign fin_go    = !cal_done_q && (cnt_inc >= cal_target_q);
	assign perm_full = cal_cnt_q >= cal_target_q;
	assign flo       = (std_floor_q == 16'd0) ? 16'd1 : std_floor_q;
	assign n16       = sub_any ? 16'(sub_cnt_q) : 16'd1;
	assign take_out  = !res_valid_q || res_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (sub_valid) state_d = ST_PWR;
			ST_PWR:     state_d = ST_AMP;
			ST_AMP: begin
				if (step_last) begin
					if (!sub_full) state_d = ST_ACC_RD;
					else if (beat_q.last_in_frame) state_d = ST_FRM;
					else state_d = ST_IDLE;
				end
			end
			ST_ACC_RD:  state_d = ST_ACC_WR;
			ST_ACC_WR:  state_d = beat_q.last_in_frame ? ST_FRM : ST_IDLE;
			ST_FRM: begin
				if (fin_go) state_d = ST_FIN_RD;
				else if (cal_done_q && sub_any) state_d = ST_SC_RD;
				else state_d = ST_MEAN_LD;
			end
			ST_FIN_RD:  state_d = ST_FIN_LD;
			ST_FIN_LD:  state_d = ST_FIN_DM;
			ST_FIN_DM:  if (step_last) state_d = ST_FIN_DP;
			ST_FIN_DP:  if (step_last) state_d = ST_FIN_VAR;
			ST_FIN_VAR: state_d = ST_FIN_SQ;
			ST_FIN_SQ:  if (step_last) state_d = ST_FIN_WR;
			ST_FIN_WR: begin
				if (!idx_last) state_d = ST_FIN_RD;
				else if (sub_any) state_d = ST_SC_RD;
				else state_d = ST_MEAN_LD;
			end
			ST_SC_RD:   state_d = ST_SC_LD;
			ST_SC_LD:   state_d = ST_SC_DIV;
			ST_SC_DIV:  if (step_last) state_d = sc_last ? ST_MEAN_LD : ST_SC_RD;
			ST_MEAN_LD: state_d = ST_MEAN;
			ST_MEAN:    if (step_last) state_d = cal_done_q ? ST_DEV_LD : ST_PERM_LD;
			ST_DEV_LD:  state_d = ST_DEV;
			ST_DEV:     if (step_last) state_d = ST_PERM_LD;
			ST_PERM_LD: state_d = perm_full ? ST_OUT : ST_PERM;
			ST_PERM:    if (step_last) state_d = ST_OUT;
			ST_OUT:     if (take_out) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memories
	logic             sum_we, sum_re, base_we, base_re, famp_we, famp_re;
	logic [IDX_W-1:0] sum_addr;
	logic [63:0]      sum_wdata, sum_rdata;
	logic [31:0]      base_wdata, base_rdata;
	logic [15:0]      famp_rdata;

	logic [31:0] asum_rd, psum_rd;
	logic [32:0] asum_add, psum_add;
	logic [15:0] sd_c;
	assign asum_rd  = vld_rd_q ? sum_rdata[63:32] : 32'd0;
	assign psum_rd  = vld_rd_q ? sum_rdata[31:0] : 32'd0;
	assign asum_add = {1'b0, asum_rd} + {17'b0, sq_rnd[15:0]};
	assign psum_add = {1'b0, psum_rd} + {17'b0, p_q};
	assign sum_wdata = {asum_add[32] ? 32'hFFFF_FFFF : asum_add[31:0],
		psum_add[32] ? 32'hFFFF_FFFF : psum_add[31:0]};
	always_comb begin
		if (sq_rnd < {16'b0, flo}) sd_c = flo;
		else if (sq_rnd > 32'h0000_FFFF) sd_c = 16'hFFFF;
		else sd_c = sq_rnd[15:0];
	end
	assign base_wdata = {mean_q, sd_c};

	// outputs
	always_comb begin
		sub_ready = 1'b0;
		sum_we    = 1'b0;
		sum_re    = 1'b0;
		base_we   = 1'b0;
		base_re   = 1'b0;
		famp_we   = 1'b0;
		famp_re   = 1'b0;
		sum_addr  = idx_q;
		case (state_q)
			ST_IDLE:   sub_ready = 1'b1;
			ST_ACC_RD: begin
				sum_re   = 1'b1;
				sum_addr = sub_cnt_q[IDX_W-1:0];
			end
			ST_ACC_WR: begin
				sum_we   = !cal_done_q;
				famp_we  = 1'b1;
				sum_addr = sub_cnt_q[IDX_W-1:0];
			end
			ST_FIN_RD: sum_re  = 1'b1;
			ST_FIN_WR: base_we = 1'b1;
			ST_SC_RD: begin
				base_re = 1'b1;
				famp_re = 1'b1;
			end
			default: ;
		endcase
	end

	cbds_ram #(.WIDTH(64), .DEPTH(MAX_SUB)) u_sum_ram (
		.clk(clk), .we(sum_we), .waddr(sum_addr), .wdata(sum_wdata),
		.re(sum_re), .raddr(sum_addr), .rdata(sum_rdata)
	);

	cbds_ram #(.WIDTH(32), .DEPTH(MAX_SUB)) u_base_ram (
		.clk(clk), .we(base_we), .waddr(idx_q), .wdata(base_wdata),
		.re(base_re), .raddr(idx_q), .rdata(base_rdata)
	);

	cbds_ram #(.WIDTH(16), .DEPTH(MAX_SUB)) u_famp_ram (
		.clk(clk), .we(famp_we), .waddr(sub_cnt_q[IDX_W-1:0]), .wdata(sq_rnd[15:0]),
		.re(famp_re), .raddr(idx_q), .rdata(famp_rdata)
	);

	// result assembly
	res_beat_t res_c;
	always_comb begin
		res_c.subcarrier_count     = 8'(sub_cnt_q);
		res_c.mean_amplitude       = mamp_q;
		res_c.avg_zscore           = dev_q;
		res_c.calibrated           = cal_done_q;
		res_c.calibration_frames   = cal_cnt_q;
		res_c.calibration_permille = perm_full ? PERM_FULL : perm_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cal_target_q <= CAL_TARGET_RST;
			std_floor_q  <= STD_FLOOR_RST;
			cnt_q        <= '0;
			idx_q        <= '0;
			sub_cnt_q    <= '0;
			cal_cnt_q    <= '0;
			cal_done_q   <= 1'b0;
			sum_vld_q    <= '0;
			vld_rd_q     <= 1'b0;
			amp_tot_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				if (paddr[2] == REG_CAL_TARGET) cal_target_q <= pwdata[15:0];
				else std_floor_q <= pwdata[15:0];
			end
			cnt_q <= ((div_run || sq_run) && !step_last) ? cnt_q + STEP_W'(1) : '0;
			if (sum_re) vld_rd_q <= sum_vld_q[sum_addr];
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_ACC_WR: begin
					if (!cal_done_q) sum_vld_q[sum_addr] <= 1'b1;
					sub_cnt_q <= sub_cnt_q + CNT_W'(1);
					amp_tot_q <= amp_tot_q + ATOT_W'(sq_rnd[15:0]);
				end
				ST_FRM: begin
					if (!cal_done_q) cal_cnt_q <= cnt_inc;
					idx_q <= '0;
				end
				ST_FIN_WR: begin
					if (idx_last) begin
						cal_done_q <= 1'b1;
						idx_q      <= '0;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_SC_DIV: if (step_last) idx_q <= idx_q + IDX_W'(1);
				ST_OUT: begin
					if (take_out) begin
						res_valid_q <= 1'b1;
						sub_cnt_q   <= '0;
						amp_tot_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (div_run) begin
			dv_num_q <= quot_nx;
			dv_rem_q <= rem_nx;
		end
		if (sq_run) begin
			if (sq_ge) begin
				sq_v_q   <= sq_v_q - sq_t;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		case (state_q)
			ST_IDLE: if (sub_valid) beat_q <= sub_beat;
			ST_PWR: begin
				p_q      <= p_c;
				sq_v_q   <= {p_c, 16'b0};
				sq_res_q <= '0;
				sq_bit_q <= SQ_BIT0;
			end
			ST_FRM: begin
				dev_tot_q <= '0;
				dev_q     <= '0;
			end
			ST_FIN_LD: begin
				psum_q   <= psum_rd;
				dv_num_q <= DV_NW'(asum_rd) + DV_NW'(cal_cnt_q >> 1);
				dv_den_q <= cal_cnt_q;
				dv_rem_q <= '0;
			end
			ST_FIN_DM: begin
				if (step_last) begin
					mean_q   <= (quot_nx > DV_NW'(16'hFFFF)) ? 16'hFFFF : quot_nx[15:0];
					dv_num_q <= DV_NW'({psum_q, 16'b0}) + DV_NW'(cal_cnt_q >> 1);
					dv_rem_q <= '0;
				end
			end
			ST_FIN_DP: begin
				if (step_last) begin
					pw_q <= (quot_nx[DV_NW-1:32] != '0) ? 32'hFFFF_FFFF : quot_nx[31:0];
					m2_q <= mean_q * mean_q;
				end
			end
			ST_FIN_VAR: begin
				sq_v_q   <= (pw_q > m2_q) ? pw_q - m2_q : '0;
				sq_res_q <= '0;
				sq_bit_q <= SQ_BIT0;
			end
			ST_SC_LD: begin
				if (famp_rdata > base_rdata[31:16]) begin
					dv_num_q <= DV_NW'({famp_rdata - base_rdata[31:16], 8'b0});
				end else begin
					dv_num_q <= DV_NW'({base_rdata[31:16] - famp_rdata, 8'b0});
				end
				if (base_rdata[15:0] == 16'd0) begin
					dv_den_q <= 16'd1;
				end else begin
					dv_num_q <= (famp_rdata > base_rdata[31:16])
						? DV_NW'({famp_rdata - base_rdata[31:16], 8'b0}) + DV_NW'(base_rdata[15:1])
						: DV_NW'({base_rdata[31:16] - famp_rdata, 8'b0}) + DV_NW'(base_rdata[15:1]);
					dv_den_q <= base_rdata[15:0];
				end
				dv_rem_q <= '0;
			end
			ST_SC_DIV: begin
				if (step_last) begin
					dev_tot_q <= dev_tot_q + ((quot_nx > DV_NW'(DEV_SAT))
						? DTOT_W'(DEV_SAT) : DTOT_W'(quot_nx[18:0]));
				end
			end
			ST_MEAN_LD: begin
				dv_num_q <= DV_NW'(amp_tot_q) + DV_NW'(n16 >> 1);
				dv_den_q <= n16;
				dv_rem_q <= '0;
			end
			ST_MEAN: if (step_last) mamp_q <= quot_nx[15:0];
			ST_DEV_LD: begin
				dv_num_q <= DV_NW'(dev_tot_q) + DV_NW'(n16 >> 1);
				dv_den_q <= n16;
				dv_rem_q <= '0;
			end
			ST_DEV: begin
				if (step_last) begin
					dev_q <= (quot_nx > DV_NW'(DEV_SAT)) ? DEV_SAT : quot_nx[18:0];
				end
			end
			ST_PERM_LD: begin
				dv_num_q <= DV_NW'(cal_cnt_q) * DV_NW'(PERM_FULL) + DV_NW'(cal_target_q >> 1);
				dv_den_q <= cal_target_q;
				dv_rem_q <= '0;
			end
			ST_PERM: begin
				if (step_last) begin
					perm_q <= (quot_nx > DV_NW'(PERM_FULL)) ? PERM_FULL : quot_nx[9:0];
				end
			end
			ST_OUT: if (take_out) res_q <= res_c;
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sub_cnt_q <= CNT_W'(MAX_SUB))
		else $error("subcarrier count past MAX_SUB");
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cal_done_q |=> cal_done_q)
		else $error("calibration flag dropped");
	a_dev_uncal: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_beat.calibrated) |-> (res_beat.avg_zscore == '0))
		else $error("deviation before calibration");
	a_perm_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_beat.calibration_permille <= PERM_FULL))
		else $error("progress above full scale");
`endif

endmodule

### hw/rtl/cbds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for all per-subcarrier stores of the scorer; no dependencies.
module cbds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sim/csi_baseline_deviation_scorer_test.sv
// Self-checking testbench for csi_baseline_deviation_scorer: random and directed frames,
// a built-in baseline/z-score predictor, APB register setup and random flow control.
// Depends on cbds_pkg and the scorer RTL.
module csi_baseline_deviation_scorer_test;
	import cbds_pkg::*;

	localparam int NSUB = MAX_SUB_DEF;
	localparam int CYCLE_LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sub_valid = 1'b0;
	logic        sub_ready;
	sub_beat_t   sub_beat = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_beat_t   res_beat;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	csi_baseline_deviation_scorer u_dut (
		.clk(clk), .arst_n(arst_n),
		.sub_valid(sub_valid), .sub_ready(sub_ready), .sub_beat(sub_beat),
		.res_valid(res_valid), .res_ready(res_ready), .res_beat(res_beat),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	sub_beat_t sub_pending[$];
	res_beat_t frame_results[$];
	int        send_idle = 28;
	int        recv_idle = 53;
	int        fails = 0;
	int        beats_in = 0;
	int        frames_out = 0;
	int        cycles = 0;

	// shadow configuration and predictor state
	logic [15:0] cfg_target = CAL_TARGET_RST;
	logic [15:0] cfg_floor  = STD_FLOOR_RST;
	logic [31:0] amp_acc [NSUB];
	logic [31:0] pwr_acc [NSUB];
	logic [15:0] base_mean [NSUB];
	logic [15:0] base_std [NSUB];
	logic [15:0] frm_amp [NSUB];
	int unsigned sub_idx = 0;
	logic [31:0] amp_tot = '0;
	int unsigned cal_cnt = 0;
	bit          cal_ok = 1'b0;

	initial begin
		for (int i = 0; i < NSUB; i++) begin
			amp_acc[i] = '0;
			pwr_acc[i] = '0;
			base_mean[i] = '0;
			base_std[i] = '0;
			frm_amp[i] = '0;
		end
	end

	function automatic logic [63:0] rsqrt(input logic [63:0] x);
		logic [63:0] res, bt, v;
		res = 0;
		bt = 64'd1 << 62;
		v = x;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		if (x - res * res > res) res = res + 1;
		return res;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic score_sub(input sub_beat_t b);
		int q, r;
		logic [31:0] p, amp, n, mean_amp, dev_tot, dev, perm;
		logic [63:0] c, flo, mn, pw, m2, vr, sd, diff, z, sdv;
		res_beat_t e;
		q = b.q_part;
		r = b.r_part;
		p = q * q + r * r;
		amp = rsqrt({32'd0, p} << 16);
		if (sub_idx < NSUB) begin
			frm_amp[sub_idx] = amp[15:0];
			amp_tot = amp_tot + amp;
			if (!cal_ok) begin
				amp_acc[sub_idx] = sat_add(amp_acc[sub_idx], amp);
				pwr_acc[sub_idx] = sat_add(pwr_acc[sub_idx], p);
			end
			sub_idx++;
		end
		if (!b.last_in_frame) return;
		n = sub_idx ? sub_idx : 1;
		mean_amp = (amp_tot + n / 2) / n;
		if (!cal_ok) begin
			if (cal_cnt < 65535) cal_cnt++;
			if (cal_cnt >= cfg_target) begin
				c = cal_cnt ? cal_cnt : 1;
				flo = cfg_floor ? cfg_floor : 1;
				for (int i = 0; i < NSUB; i++) begin
					mn = ({32'd0, amp_acc[i]} + c / 2) / c;
					pw = (({32'd0, pwr_acc[i]} << 16) + c / 2) / c;
					m2 = mn * mn;
					vr = pw > m2 ? pw - m2 : 0;
					sd = rsqrt(vr);
					if (sd < flo) sd = flo;
					if (mn > 64'hFFFF) mn = 64'hFFFF;
					if (sd > 64'hFFFF) sd = 64'hFFFF;
					base_mean[i] = mn[15:0];
					base_std[i] = sd[15:0];
				end
				cal_ok = 1'b1;
			end
		end
		dev = 0;
		dev_tot = 0;
		if (cal_ok) begin
			for (int i = 0; i < sub_idx && i < NSUB; i++) begin
				sdv = base_std[i] ? base_std[i] : 1;
				diff = frm_amp[i] > base_mean[i] ? frm_amp[i] - base_mean[i]
					: base_mean[i] - frm_amp[i];
				z = ((diff << 8) + sdv / 2) / sdv;
				if (z > DEV_SAT) z = DEV_SAT;
				dev_tot = dev_tot + z[31:0];
			end
			dev = (dev_tot + n / 2) / n;
			if (dev > DEV_SAT) dev = DEV_SAT;
		end
		if (cal_cnt >= cfg_target) begin
			perm = PERM_FULL;
		end else begin
			perm = (cal_cnt * 1000 + cfg_target / 2) / cfg_target;
			if (perm > PERM_FULL) perm = PERM_FULL;
		end
		e.subcarrier_count = sub_idx[7:0];
		e.mean_amplitude = mean_amp[15:0];
		e.avg_zscore = dev[18:0];
		e.calibrated = cal_ok;
		e.calibration_frames = cal_cnt[15:0];
		e.calibration_permille = perm[9:0];
		frame_results.push_back(e);
		sub_idx = 0;
		amp_tot = 0;
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch frame %0d %s: got %0d want %0d", frames_out, what, got, want);
		fails++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (sub_valid && sub_ready) begin
				score_sub(sub_beat);
				beats_in++;
			end
			if (!sub_valid || sub_ready) begin
				if (sub_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					sub_valid <= 1'b1;
					sub_beat <= sub_pending.pop_front();
				end else begin
					sub_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_beat_t w;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (frame_results.size() == 0) begin
					$display("unexpected result beat after %0d frames", frames_out);
					fails++;
				end else begin
					w = frame_results.pop_front();
					if (res_beat.subcarrier_count != w.subcarrier_count)
						report("subcarrier_count", res_beat.subcarrier_count, w.subcarrier_count);
					if (res_beat.mean_amplitude != w.mean_amplitude)
						report("mean_amplitude", res_beat.mean_amplitude, w.mean_amplitude);
					if (res_beat.avg_zscore != w.avg_zscore)
						report("avg_zscore", res_beat.avg_zscore, w.avg_zscore);
					if (res_beat.calibrated != w.calibrated)
						report("calibrated", res_beat.calibrated, w.calibrated);
					if (res_beat.calibration_frames != w.calibration_frames)
						report("calibration_frames", res_beat.calibration_frames,
							w.calibration_frames);
					if (res_beat.calibration_permille != w.calibration_permille)
						report("calibration_permille", res_beat.calibration_permille,
							w.calibration_permille);
				end
				frames_out++;
			end
			res_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic apb_write(input logic reg_sel, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_CAL_TARGET) cfg_target = val;
		else cfg_floor = val;
	endtask

	task automatic push_sub(input int q, input int r, input bit last);
		sub_beat_t b;
		b.q_part = q[7:0];
		b.r_part = r[7:0];
		b.last_in_frame = last;
		sub_pending.push_back(b);
	endtask

	// frames mostly near a per-subcarrier profile, some fully random, a few oversized
	task automatic push_frames(input int items);
		int n, q, r, left;
		bit wild;
		left = items;
		while (left > 0) begin
			n = ($urandom_range(0, 14) == 0) ? $urandom_range(120, 132)
				: $urandom_range(1, 10);
			wild = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < n; i++) begin
				if (wild) begin
					q = $urandom_range(0, 255);
					r = $urandom_range(0, 255);
				end else begin
					q = ((i * 7) % 90) - 45 + $urandom_range(0, 6) - 3;
					r = 30 - (i % 50) + $urandom_range(0, 4) - 2;
				end
				push_sub(q, r, i == n - 1);
			end
			left -= n;
		end
	endtask

	task automatic drain(input int tail);
		while (sub_pending.size() != 0 || sub_valid || frame_results.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		apb_write(REG_CAL_TARGET, 16'hFFFF);
		apb_write(REG_STD_FLOOR, 16'hFFFF);
		// extremes of the components, a one-subcarrier frame
		push_sub(-128, -128, 0);
		push_sub(127, 127, 0);
		push_sub(0, 0, 0);
		push_sub(-128, 127, 0);
		push_sub(127, -128, 1);
		push_sub(0, 0, 1);
		push_sub(1, -1, 0);
		push_sub(-1, 1, 0);
		push_sub(85, -42, 1);
		drain(60);
		// lowering the target finishes calibration a few frames later
		apb_write(REG_CAL_TARGET, 16'd6);
		apb_write(REG_STD_FLOOR, 16'd1);
		push_frames(200);
		drain(60);
		send_idle = 53;
		recv_idle = 28;
		apb_write(REG_CAL_TARGET, 16'hFFFF);
		apb_write(REG_STD_FLOOR, STD_FLOOR_RST);
		push_frames(220);
		drain(60);
		send_idle = 0;
		recv_idle = 0;
		apb_write(REG_CAL_TARGET, 16'd1);
		apb_write(REG_STD_FLOOR, 16'($urandom_range(1, 65535)));
		push_frames(220);
		drain(300);
		$display("%0d subcarrier beats in, %0d frame results checked, %0d cycles",
			beats_in, frames_out, cycles);
		$display("calibration and scoring covered under three flow-control regimes");
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", fails);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
